// ===== rtl/srld_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srld_pkg
// Shared types and constants of the sprite run-length decoder.
// ----------------------------------------------------------------------------
package srld_pkg;

	localparam int unsigned IDX_W        = 16;
	localparam int unsigned LEN_W        = 16;
	localparam int unsigned OFS_W        = 11;
	localparam int unsigned POS_W        = 12;
	localparam int unsigned COLOR_W      = 8;
	localparam int unsigned CFG_DATA_W   = 16;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned QUEUE_DEPTH  = 2;
	localparam int unsigned TILE_WIDTH_D = 32;

	localparam logic [LEN_W-1:0] MAX_BODY_RESET = 16'd3444;
	localparam logic [LEN_W-1:0] MAX_RUN_RESET  = 16'd3076;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_X_OFFSET  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_Y_OFFSET  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_RUN   = 2'd3;

	typedef enum logic [1:0] {
		KIND_PIXEL   = 2'd0,
		KIND_END     = 2'd1,
		KIND_BAD_LEN = 2'd2,
		KIND_BAD_RUN = 2'd3
	} kind_t;

	typedef enum logic [6:0] {
		PH_LEN_LO = 7'b0000001,
		PH_LEN_HI = 7'b0000010,
		PH_RUN_LO = 7'b0000100,
		PH_RUN_HI = 7'b0001000,
		PH_RED    = 7'b0010000,
		PH_GREEN  = 7'b0100000,
		PH_BLUE   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [OFS_W-1:0] x_offset;
		logic [OFS_W-1:0] y_offset;
		logic [LEN_W-1:0] max_body_bytes;
		logic [LEN_W-1:0] max_run_pixels;
	} srld_cfg_t;

	typedef struct packed {
		kind_t              kind;
		logic [IDX_W-1:0]   index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last;
	} srld_item_t;

endpackage
`default_nettype wire

// ===== rtl/srld_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srld_if
// Valid/ready channels of the decoder: byte stream in, results out.
// ----------------------------------------------------------------------------
interface srld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface srld_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [11:0] column;
	logic [11:0] row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last;

	modport source (output valid, output kind, output column, output row,
		output red, output green, output blue, output last, input ready);
	modport sink   (input valid, input kind, input column, input row,
		input red, input green, input blue, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sprite_run_length_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_run_length_decoder
// Transparent/solid run-length sprite decoder, one stream byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries the encoded sprite, one byte per transfer: a 16-bit
//   little-endian body length, then alternating transparent and solid run
//   counts, each solid pixel followed by red, green and blue bytes.
//   result carries at most one item per byte: a pixel (on its blue byte)
//   with tile position and color, a sprite end without pixel, or a length
//   or run error, after which the decoder expects a new length.
//   cfg_we/cfg_index/cfg_data write x_offset, y_offset, max_body_bytes and
//   max_run_pixels; write them only while no result is outstanding.
// Timing:
//   One byte per cycle sustained while results are taken. A result passes the
//   two-entry queue, which the parser pushes it into at the edge that takes
//   the byte; the reciprocal multiply for index/tile width then takes one
//   register stage and the remainder and offsets another.
// Reset: parser waits for a length low byte, queue and pipeline empty,
//   registers at their defaults (offsets 0, limits 3444 and 3076).
// Stall: a stalled result holds in the output register; the pipeline and
//   the queue keep filling, and stream.ready drops once the queue is full.
// ----------------------------------------------------------------------------
module sprite_run_length_decoder #(
	parameter int unsigned TILE_WIDTH = srld_pkg::TILE_WIDTH_D
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [srld_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [srld_pkg::CFG_DATA_W-1:0]     cfg_data,
	srld_in_if.sink                                  stream,
	srld_out_if.source                               result
);
	import srld_pkg::*;

	srld_cfg_t  cfg_q;
	logic       take;
	logic       push;
	srld_item_t push_item;
	logic       q_not_full;
	logic       q_not_empty;
	logic       pop;
	srld_item_t head;

	// Register file: plain writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_offset       <= '0;
			cfg_q.y_offset       <= '0;
			cfg_q.max_body_bytes <= MAX_BODY_RESET;
			cfg_q.max_run_pixels <= MAX_RUN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_X_OFFSET: cfg_q.x_offset       <= cfg_data[OFS_W-1:0];
				REG_Y_OFFSET: cfg_q.y_offset       <= cfg_data[OFS_W-1:0];
				REG_MAX_BODY: cfg_q.max_body_bytes <= cfg_data[LEN_W-1:0];
				REG_MAX_RUN:  cfg_q.max_run_pixels <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Accept a byte whenever the queue has room; every byte may push one item
	assign stream.ready = q_not_full;
	assign take         = stream.valid && stream.ready;

	srld_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.take        (take),
		.stream_byte (stream.stream_byte),
		.push        (push),
		.item        (push_item)
	);

	srld_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	srld_back #(
		.TILE_WIDTH (TILE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (q_not_empty),
		.item       (head),
		.pop        (pop),
		.result     (result)
	);

	// The parser only pushes on an accepted byte, which needs queue room
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (take && q_not_full))
		else $error("item pushed into a full queue");

	// Non-pixel results carry an all-zero payload
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind != KIND_PIXEL) |->
		(result.column == '0 && result.row == '0 && result.red == '0 &&
		 result.green == '0 && result.blue == '0 && !result.last))
		else $error("status result with nonzero payload");

	// The position stage never drains an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_not_empty)
		else $error("pop from an empty queue");

	// A newly valid result came from an item that had been in the queue
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(q_not_empty, 2))
		else $error("result without a queued item");

endmodule
`default_nettype wire

// ===== rtl/srld_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srld_front
// Byte parser: walks header, run counts and colors, emits result items.
// ----------------------------------------------------------------------------
module srld_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire srld_pkg::srld_cfg_t     cfg,
	input  wire logic                    take,
	input  wire logic [7:0]              stream_byte,
	output logic                         push,
	output srld_pkg::srld_item_t         item
);
	import srld_pkg::*;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   consumed_q, consumed_d;
	logic [LEN_W-1:0]   body_q, body_d;
	logic [LEN_W-1:0]   run_left_q, run_left_d;
	logic [IDX_W-1:0]   pix_q, pix_d;
	logic               solid_q, solid_d;
	logic [7:0]         low_q;
	logic [COLOR_W-1:0] red_q, green_q;

	logic [LEN_W-1:0]   consumed_inc;
	logic [LEN_W-1:0]   word;
	logic [LEN_W-1:0]   run_dec;
	logic               more_body;

	assign word    = {stream_byte, low_q};
	assign run_dec = run_left_q - LEN_W'(1);

	always_comb begin
		consumed_inc = consumed_q;
		if (phase_q != PH_LEN_LO && phase_q != PH_LEN_HI && consumed_q != '1)
			consumed_inc = consumed_q + LEN_W'(1);
	end

	// Sprite continues while consumed (counting this byte) + 1 < body length
	assign more_body = ({1'b0, consumed_inc} + 17'd1) < {1'b0, body_q};

	always_comb begin
		phase_d    = phase_q;
		consumed_d = consumed_q;
		body_d     = body_q;
		run_left_d = run_left_q;
		pix_d      = pix_q;
		solid_d    = solid_q;
		push       = 1'b0;
		item       = '{kind: KIND_PIXEL, index: pix_q, red: red_q, green: green_q,
			blue: stream_byte, last: 1'b0};
		if (take) begin
			consumed_d = consumed_inc;
			case (phase_q)
				PH_LEN_LO: begin
					phase_d = PH_LEN_HI;
				end
				PH_LEN_HI: begin
					consumed_d = '0;
					pix_d      = '0;
					solid_d    = 1'b0;
					run_left_d = '0;
					if (word > cfg.max_body_bytes) begin
						phase_d = PH_LEN_LO;
						body_d  = '0;
						push    = 1'b1;
						item    = '{kind: KIND_BAD_LEN, default: '0};
					end else if (17'd1 < {1'b0, word}) begin
						phase_d = PH_RUN_LO;
						body_d  = word;
					end else begin
						// short body ends at once
						phase_d = PH_LEN_LO;
						body_d  = '0;
						push    = 1'b1;
						item    = '{kind: KIND_END, default: '0};
					end
				end
				PH_RUN_LO: begin
					phase_d = PH_RUN_HI;
				end
				PH_RUN_HI: begin
					if (word > cfg.max_run_pixels) begin
						phase_d    = PH_LEN_LO;
						consumed_d = '0;
						body_d     = '0;
						run_left_d = '0;
						pix_d      = '0;
						solid_d    = 1'b0;
						push       = 1'b1;
						item       = '{kind: KIND_BAD_RUN, default: '0};
					end else if (solid_q && word != '0) begin
						run_left_d = word;
						phase_d    = PH_RED;
					end else begin
						if (!solid_q)
							pix_d = pix_q + word;
						solid_d = !solid_q;
						if (more_body) begin
							phase_d = PH_RUN_LO;
						end else begin
							phase_d    = PH_LEN_LO;
							consumed_d = '0;
							body_d     = '0;
							run_left_d = '0;
							pix_d      = '0;
							solid_d    = 1'b0;
							push       = 1'b1;
							item       = '{kind: KIND_END, default: '0};
						end
					end
				end
				PH_RED: begin
					phase_d = PH_GREEN;
				end
				PH_GREEN: begin
					phase_d = PH_BLUE;
				end
				PH_BLUE: begin
					push       = 1'b1;
					pix_d      = pix_q + IDX_W'(1);
					run_left_d = run_dec;
					if (run_dec == '0) begin
						solid_d = !solid_q;
						if (more_body) begin
							phase_d = PH_RUN_LO;
						end else begin
							phase_d    = PH_LEN_LO;
							consumed_d = '0;
							body_d     = '0;
							run_left_d = '0;
							pix_d      = '0;
							solid_d    = 1'b0;
							item.last  = 1'b1;
						end
					end else begin
						phase_d = PH_RED;
					end
				end
				default: begin
					phase_d    = PH_LEN_LO;
					consumed_d = '0;
					body_d     = '0;
					run_left_d = '0;
					pix_d      = '0;
					solid_d    = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_LEN_LO;
			consumed_q <= '0;
			body_q     <= '0;
			run_left_q <= '0;
			pix_q      <= '0;
			solid_q    <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			consumed_q <= consumed_d;
			body_q     <= body_d;
			run_left_q <= run_left_d;
			pix_q      <= pix_d;
			solid_q    <= solid_d;
		end
	end

	// Hold the low byte of a 16-bit count and the first two colors
	always_ff @(posedge clk) begin
		if (take && (phase_q == PH_LEN_LO || phase_q == PH_RUN_LO))
			low_q <= stream_byte;
		if (take && phase_q == PH_RED)
			red_q <= stream_byte;
		if (take && phase_q == PH_GREEN)
			green_q <= stream_byte;
	end

endmodule
`default_nettype wire

// ===== rtl/srld_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srld_queue
// Short FIFO of result items between the parser and the position stage.
// ----------------------------------------------------------------------------
module srld_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	input  wire srld_pkg::srld_item_t    push_item,
	output logic                         not_full,
	input  wire logic                    pop,
	output logic                         not_empty,
	output srld_pkg::srld_item_t         head
);
	import srld_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	srld_item_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push, do_pop;

	assign not_full  = count_q != CNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign head      = slot_q[rd_ptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		r = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_item;
	end

endmodule
`default_nettype wire

// ===== rtl/srld_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srld_back
// Position stage: splits the pixel index into tile row and column.
// ----------------------------------------------------------------------------
module srld_back #(
	parameter int unsigned TILE_WIDTH = srld_pkg::TILE_WIDTH_D
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire srld_pkg::srld_cfg_t     cfg,
	input  wire logic                    item_valid,
	input  wire srld_pkg::srld_item_t    item,
	output logic                         pop,
	srld_out_if.source                   result
);
	import srld_pkg::*;

	// index / TILE_WIDTH as (index * RECIP) >> SHIFT, exact for 16-bit index
	localparam int unsigned TW_LOG  = $clog2(TILE_WIDTH);
	localparam int unsigned SHIFT   = IDX_W + TW_LOG;
	localparam int unsigned PROD_W  = SHIFT + IDX_W;
	localparam logic [63:0] RECIP_F =
		((64'd1 << SHIFT) + 64'(TILE_WIDTH) - 64'd1) / 64'(TILE_WIDTH);
	localparam logic [PROD_W-1:0] RECIP = RECIP_F[PROD_W-1:0];
	localparam int unsigned REM_W   = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
	localparam int unsigned QW_W    = IDX_W + 9;

	srld_item_t         item_s1;
	logic [IDX_W-1:0]   quot_s1;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv_s1, adv_s2;

	logic [PROD_W-1:0]  prod;
	logic [QW_W-1:0]    qw;
	logic [QW_W-1:0]    rem_full;
	logic [REM_W-1:0]   rem;
	logic [POS_W-1:0]   column_d, row_d;
	logic               is_pixel;

	assign adv_s2 = !valid_s2 || result.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = item_valid && adv_s1;

	assign prod     = PROD_W'(item.index) * RECIP;
	assign qw       = QW_W'(quot_s1) * QW_W'(TILE_WIDTH);
	assign rem_full = QW_W'(item_s1.index) - qw;
	assign rem      = rem_full[REM_W-1:0];
	assign is_pixel = item_s1.kind == KIND_PIXEL;
	assign column_d = is_pixel ? POS_W'(cfg.x_offset) + POS_W'(rem) : '0;
	assign row_d    = is_pixel ? POS_W'(cfg.y_offset) + quot_s1[POS_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= item_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s1 <= item;
			quot_s1 <= prod[SHIFT +: IDX_W];
		end
		if (adv_s2 && valid_s1) begin
			result.kind   <= item_s1.kind;
			result.column <= column_d;
			result.row    <= row_d;
			result.red    <= item_s1.red;
			result.green  <= item_s1.green;
			result.blue   <= item_s1.blue;
			result.last   <= item_s1.last;
		end
	end

	assign result.valid = valid_s2;

endmodule
`default_nettype wire
